// ===== src/cfn_pkg.sv =====
package cfn_pkg;

   // Default sizing of the column store
   localparam int COLUMNS_DEF     = 16;
   localparam int MAX_RECORDS_DEF = 1048576;

   // Iteration counts of the shared shift/subtract unit
   localparam int DIV_STEPS  = 64;
   localparam int SQRT_STEPS = 32;

   // Opcodes of an input beat
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LEARN = 2'd1;
   localparam logic [1:0] OP_APPLY = 2'd2;

   // Result status codes
   localparam logic [1:0] STAT_CLEARED = 2'd0;
   localparam logic [1:0] STAT_LEARNED = 2'd1;
   localparam logic [1:0] STAT_APPLIED = 2'd2;
   localparam logic [1:0] STAT_IGNORED = 2'd3;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [3:0]         column;
      logic signed [31:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [31:0] normalized;
      logic signed [31:0] center_param;
      logic signed [31:0] spread_param;
      logic               divided;
      logic [1:0]         status;
   } rsp_type;

   // Command to the shared divide / square-root unit
   typedef struct packed {
      logic        go;
      logic        sqrt;
      logic [63:0] num;
      logic [31:0] den;
   } cfn_cmd_type;

   // Completion from the shared unit
   typedef struct packed {
      logic        done;
      logic [63:0] value;
   } cfn_res_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV_MEAN,
      ST_MUL,
      ST_M2,
      ST_DIV_VAR,
      ST_SQRT,
      ST_APPLY,
      ST_DIV_NORM,
      ST_DONE
   } state_type;

   // Apply a sign to a magnitude and saturate to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic neg, input logic [63:0] mag);
      logic signed [31:0] r;
      if (neg) begin
         if (mag > 64'h0000_0000_8000_0000) r = 32'sh8000_0000;
         else r = signed'(~mag[31:0] + 32'd1);
      end else begin
         if (mag > 64'h0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
         else r = signed'(mag[31:0]);
      end
      return r;
   endfunction

endpackage

// ===== src/cfn_divsqrt.sv =====
module cfn_divsqrt (
   input  logic                 clock,
   input  logic                 reset,
   input  cfn_pkg::cfn_cmd_type cmd,
   output cfn_pkg::cfn_res_type res
);
   import cfn_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        sqrt_ff, sqrt_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] acc_ff, acc_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [31:0] den_ff, den_in;

   logic [35:0] op_a, op_b;
   logic [36:0] diff;
   logic        ge;

   // Shared subtractor: divide shifts one bit in, square root two
   assign op_a = sqrt_ff ? {rem_ff, acc_ff[63:62]} : {3'b0, rem_ff[31:0], acc_ff[63]};
   assign op_b = sqrt_ff ? {2'b0, root_ff, 2'b01} : {4'b0, den_ff};
   assign diff = {1'b0, op_a} - {1'b0, op_b};
   assign ge   = ~diff[36];

   // Advance one step per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      sqrt_in = sqrt_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      den_in  = den_ff;
      if (busy_ff) begin
         rem_in = ge ? diff[33:0] : op_a[33:0];
         if (sqrt_ff) begin
            acc_in  = {acc_ff[61:0], 2'b00};
            root_in = {root_ff[30:0], ge};
         end else begin
            acc_in = {acc_ff[62:0], ge};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (cmd.go) begin
         busy_in = 1'b1;
         sqrt_in = cmd.sqrt;
         cnt_in  = cmd.sqrt ? 6'(SQRT_STEPS - 1) : 6'(DIV_STEPS - 1);
         acc_in  = cmd.num;
         rem_in  = '0;
         root_in = '0;
         den_in  = cmd.den;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      sqrt_ff <= sqrt_in;
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      den_ff  <= den_in;
   end

   assign res.done  = done_ff;
   assign res.value = sqrt_ff ? {32'b0, root_ff} : acc_ff;

endmodule

// ===== src/column_feature_normalizer.sv =====
// Channel   Ports                              Direction  Accept
// command   start, busy, req_item              in         start && !busy
// result    rsp_valid, rsp_item                out        every cycle rsp_valid is high
// config    psel, penable, pwrite, paddr, ...  in         psel && penable && pwrite
//
// One beat at a time. Clear, ignored and first-sample learn beats go from the load
// state straight to the result. A later learn runs a 64-step divide of the mean delta
// by the count in the shared shift/subtract unit, then four 24x24 partial products.
// The first apply on a column of two or more samples runs a 64-step divide and a
// 32-step square root; an apply with a divided result runs one more divide.
// Reset is synchronous and marks every column empty at once. The result
// strobe lasts one cycle and cannot be held off.
module column_feature_normalizer #(
   parameter int COLUMNS     = cfn_pkg::COLUMNS_DEF,
   parameter int MAX_RECORDS = cfn_pkg::MAX_RECORDS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cfn_pkg::req_type req_item,
   output logic             rsp_valid,
   output cfn_pkg::rsp_type rsp_item,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import cfn_pkg::*;

   localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int NW = $clog2(MAX_RECORDS + 1);

   // Configuration registers
   logic        mode_ff;
   logic [15:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         thr_ff  <= 16'd7;
      end else if (psel && penable && pwrite) begin
         if (paddr[2]) thr_ff <= pwdata[15:0];
         else mode_ff <= pwdata[0];
      end
   end

   assign pready = 1'b1;
   assign prdata = paddr[2] ? {16'b0, thr_ff} : {31'b0, mode_ff};

   // Column store
   logic [COLUMNS-1:0] valid_ff;
   logic [NW-1:0]      cnt_ff  [COLUMNS];
   logic [47:0]        mean_ff [COLUMNS];
   logic [63:0]        m2_ff   [COLUMNS];
   logic [31:0]        min_ff  [COLUMNS];
   logic [31:0]        max_ff  [COLUMNS];
   logic [31:0]        fs_ff   [COLUMNS];
   logic [COLUMNS-1:0] frz_ff;

   // Beat and working registers
   state_type          state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic [3:0]         col_ff, col_in;
   logic [31:0]        x_ff, x_in;
   logic               neg_ff, neg_in;
   logic [NW-1:0]      n_ff, n_in;
   logic [47:0]        mnew_ff, mnew_in;
   logic [47:0]        ma_ff, ma_in;
   logic [47:0]        mb_ff, mb_in;
   logic [2:0]         mcnt_ff, mcnt_in;
   logic [47:0]        prod_ff, prod_in;
   logic [1:0]         psh_ff, psh_in;
   logic [95:0]        macc_ff, macc_in;
   logic [31:0]        sd_ff, sd_in;
   rsp_type            rsp_ff, rsp_in;

   cfn_cmd_type        cmd;
   cfn_res_type        res;

   // Store write port
   logic               wr_en, clr;
   logic [NW-1:0]      wr_cnt;
   logic [47:0]        wr_mean;
   logic [63:0]        wr_m2;
   logic [31:0]        wr_min, wr_max, wr_fs;
   logic               wr_frz;

   // Read the addressed column; an empty column reads as zero
   logic [CW+3:0]      col_ext;
   logic [CW-1:0]      idx;
   logic               hit, rd_ok;
   logic [NW-1:0]      rd_cnt;
   logic [47:0]        rd_mean;
   logic [63:0]        rd_m2;
   logic [31:0]        rd_min, rd_max, rd_fs;
   logic               rd_frz;

   assign col_ext = {{CW{1'b0}}, col_ff};
   assign idx     = col_ext[CW-1:0];
   assign hit     = 32'(col_ff) < COLUMNS;
   assign rd_ok   = hit && valid_ff[idx];
   assign rd_cnt  = rd_ok ? cnt_ff[idx] : '0;
   assign rd_mean = rd_ok ? mean_ff[idx] : '0;
   assign rd_m2   = rd_ok ? m2_ff[idx] : '0;
   assign rd_min  = rd_ok ? min_ff[idx] : '0;
   assign rd_max  = rd_ok ? max_ff[idx] : '0;
   assign rd_fs   = rd_ok ? fs_ff[idx] : '0;
   assign rd_frz  = rd_ok && frz_ff[idx];

   // Datapath terms
   logic [47:0] xq;
   logic [48:0] delta, delta_mag;
   logic [47:0] q48, mean_upd;
   logic [48:0] e_new, e_mag;
   logic [47:0] mean_mag;
   logic [32:0] r33;
   logic [34:0] e_rng;
   logic [34:0] e_rng_mag;
   logic [64:0] m2_sum;
   logic [63:0] m2_new;
   logic [23:0] a_sel, b_sel;

   assign xq        = {x_ff, 16'b0};
   assign delta     = {xq[47], xq} - {rd_mean[47], rd_mean};
   assign delta_mag = delta[48] ? (~delta + 49'd1) : delta;
   assign q48       = res.value[47:0];
   assign mean_upd  = neg_ff ? (rd_mean - q48) : (rd_mean + q48);
   assign e_new     = {xq[47], xq} - {mean_upd[47], mean_upd};
   assign e_mag     = e_new[48] ? (~e_new + 49'd1) : e_new;
   assign mean_mag  = rd_mean[47] ? (~rd_mean + 48'd1) : rd_mean;
   assign r33       = {rd_max[31], rd_max} - {rd_min[31], rd_min};
   assign e_rng     = {{2{x_ff[31]}}, x_ff, 1'b0} - {{3{rd_min[31]}}, rd_min}
                      - {{3{rd_max[31]}}, rd_max};
   assign e_rng_mag = e_rng[34] ? (~e_rng + 35'd1) : e_rng;
   assign m2_sum    = {1'b0, rd_m2} + {1'b0, macc_ff[95:32]};
   assign m2_new    = m2_sum[64] ? '1 : m2_sum[63:0];
   assign a_sel     = mcnt_ff[1] ? ma_ff[47:24] : ma_ff[23:0];
   assign b_sel     = mcnt_ff[0] ? mb_ff[47:24] : mb_ff[23:0];

   // Sequencer
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      col_in   = col_ff;
      x_in     = x_ff;
      neg_in   = neg_ff;
      n_in     = n_ff;
      mnew_in  = mnew_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      mcnt_in  = mcnt_ff;
      prod_in  = prod_ff;
      psh_in   = psh_ff;
      macc_in  = macc_ff;
      sd_in    = sd_ff;
      rsp_in   = rsp_ff;
      cmd      = '0;
      wr_en    = 1'b0;
      clr      = 1'b0;
      wr_cnt   = rd_cnt;
      wr_mean  = rd_mean;
      wr_m2    = rd_m2;
      wr_min   = rd_min;
      wr_max   = rd_max;
      wr_fs    = rd_fs;
      wr_frz   = rd_frz;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req_item.opcode;
               col_in   = req_item.column;
               x_in     = req_item.sample;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            rsp_in        = '0;
            rsp_in.status = STAT_IGNORED;
            state_in      = ST_DONE;
            n_in          = rd_cnt + NW'(1);
            if (hit) begin
               case (op_ff)
                  OP_CLEAR: begin
                     clr           = 1'b1;
                     rsp_in.status = STAT_CLEARED;
                  end
                  OP_LEARN: begin
                     if (!rd_frz && rd_cnt < NW'(MAX_RECORDS)) begin
                        if (rd_cnt == '0) begin
                           // first sample seeds every statistic
                           wr_en         = 1'b1;
                           wr_cnt        = NW'(1);
                           wr_mean       = xq;
                           wr_m2         = '0;
                           wr_min        = x_ff;
                           wr_max        = x_ff;
                           wr_fs         = '0;
                           wr_frz        = 1'b0;
                           rsp_in.status = STAT_LEARNED;
                        end else begin
                           cmd.go   = 1'b1;
                           cmd.num  = 64'(delta_mag);
                           cmd.den  = 32'(n_in);
                           neg_in   = delta[48];
                           ma_in    = delta_mag[47:0];
                           state_in = ST_DIV_MEAN;
                        end
                     end
                  end
                  OP_APPLY: begin
                     if (rd_cnt != '0) begin
                        if (rd_frz) begin
                           sd_in    = rd_fs;
                           state_in = ST_APPLY;
                        end else if (rd_cnt < NW'(2)) begin
                           sd_in    = '0;
                           state_in = ST_APPLY;
                        end else begin
                           cmd.go   = 1'b1;
                           cmd.num  = rd_m2;
                           cmd.den  = 32'(rd_cnt - NW'(1));
                           state_in = ST_DIV_VAR;
                        end
                     end
                  end
                  default: begin
                     rsp_in.status = STAT_IGNORED;
                  end
               endcase
            end
         end
         ST_DIV_MEAN: begin
            if (res.done) begin
               mnew_in  = mean_upd;
               mb_in    = e_mag[47:0];
               mcnt_in  = '0;
               macc_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // one partial product a cycle, accumulate the previous one
            if (mcnt_ff != 3'd4) begin
               prod_in = 48'(a_sel) * 48'(b_sel);
               psh_in  = 2'(mcnt_ff[1]) + 2'(mcnt_ff[0]);
            end
            if (mcnt_ff != 3'd0) begin
               macc_in = macc_ff + (96'(prod_ff) << (24 * psh_ff));
            end
            mcnt_in = mcnt_ff + 3'd1;
            if (mcnt_ff == 3'd4) state_in = ST_M2;
         end
         ST_M2: begin
            wr_en         = 1'b1;
            wr_cnt        = n_ff;
            wr_mean       = mnew_ff;
            wr_m2         = m2_new;
            wr_min        = ($signed(x_ff) < $signed(rd_min)) ? x_ff : rd_min;
            wr_max        = ($signed(x_ff) > $signed(rd_max)) ? x_ff : rd_max;
            rsp_in        = '0;
            rsp_in.status = STAT_LEARNED;
            state_in      = ST_DONE;
         end
         ST_DIV_VAR: begin
            if (res.done) begin
               cmd.go   = 1'b1;
               cmd.sqrt = 1'b1;
               cmd.num  = res.value;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (res.done) begin
               sd_in    = res.value[31:0];
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            // freeze the column with its deviation
            wr_en         = 1'b1;
            wr_fs         = sd_ff;
            wr_frz        = 1'b1;
            rsp_in        = '0;
            rsp_in.status = STAT_APPLIED;
            state_in      = ST_DONE;
            if (!mode_ff) begin
               rsp_in.center_param = sat32(rd_mean[47], 64'(mean_mag[47:16]));
               rsp_in.spread_param = sat32(1'b0, 64'(sd_ff));
               if (sd_ff > 32'(thr_ff)) begin
                  cmd.go         = 1'b1;
                  cmd.num        = 64'(delta_mag);
                  cmd.den        = sd_ff;
                  neg_in         = delta[48];
                  rsp_in.divided = 1'b1;
                  state_in       = ST_DIV_NORM;
               end else begin
                  rsp_in.normalized = sat32(delta[48], 64'(delta_mag[48:16]));
               end
            end else begin
               rsp_in.center_param = rd_min;
               rsp_in.spread_param = rd_max;
               if (r33[31:0] > 32'(thr_ff)) begin
                  cmd.go         = 1'b1;
                  cmd.num        = {15'b0, e_rng_mag[33:0], 15'b0};
                  cmd.den        = r33[31:0];
                  neg_in         = e_rng[34];
                  rsp_in.divided = 1'b1;
                  state_in       = ST_DIV_NORM;
               end else begin
                  rsp_in.normalized = sat32(e_rng[34], 64'(e_rng_mag[34:1]));
               end
            end
         end
         ST_DIV_NORM: begin
            if (res.done) begin
               rsp_in.normalized = sat32(neg_ff, res.value);
               state_in          = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (clr) valid_ff[idx] <= 1'b0;
         else if (wr_en) valid_ff[idx] <= 1'b1;
      end
   end

   // Column store write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cnt_ff[idx]  <= wr_cnt;
         mean_ff[idx] <= wr_mean;
         m2_ff[idx]   <= wr_m2;
         min_ff[idx]  <= wr_min;
         max_ff[idx]  <= wr_max;
         fs_ff[idx]   <= wr_fs;
         frz_ff[idx]  <= wr_frz;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      col_ff  <= col_in;
      x_ff    <= x_in;
      neg_ff  <= neg_in;
      n_ff    <= n_in;
      mnew_ff <= mnew_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      mcnt_ff <= mcnt_in;
      prod_ff <= prod_in;
      psh_ff  <= psh_in;
      macc_ff <= macc_in;
      sd_ff   <= sd_in;
      rsp_ff  <= rsp_in;
   end

   cfn_divsqrt u_divsqrt (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .res   (res)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_item  = rsp_ff;

endmodule

// ===== src/cfn_checker.sv =====
module cfn_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // An accepted beat holds the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted beat did not raise busy");

   // A result only appears while a beat is in flight
   a_rsp_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result strobe while idle");

   // One result per beat
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");

   // Ready again right after the result
   a_rsp_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy held after result");

endmodule

bind column_feature_normalizer cfn_checker u_cfn_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
